// ===== hw/rtl/mus_to_midi_event_converter_core_macros.svh =====
// Assertion macros used by the converter's checker, mtm_checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef MUS_TO_MIDI_EVENT_CONVERTER_CORE_MACROS_SVH
`define MUS_TO_MIDI_EVENT_CONVERTER_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MTM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked at the following clock edge.
`define MTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mtm_pkg.sv =====
// Shared types, constants and the controller table for the MUS to MIDI converter.
// Depends on nothing.
package mtm_pkg;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_EVENT = 4'b0001,
        PH_OP1   = 4'b0010,
        PH_OP2   = 4'b0100,
        PH_DELAY = 4'b1000
    } phase_t;

    // MUS event kinds
    localparam logic [2:0] KIND_RELEASE = 3'd0;
    localparam logic [2:0] KIND_PLAY    = 3'd1;
    localparam logic [2:0] KIND_PITCH   = 3'd2;
    localparam logic [2:0] KIND_SYSTEM  = 3'd3;
    localparam logic [2:0] KIND_CTRL    = 3'd4;
    localparam logic [2:0] KIND_BAD_LO  = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;
    localparam logic [2:0] KIND_BAD_HI  = 3'd7;

    // MIDI status nibbles
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_PITCH    = 8'hE0;

    // End-of-track meta event
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;

    localparam logic [7:0] VOL_MAX   = 8'd127;
    localparam logic [7:0] VOL_RESET = 8'd64;

    localparam logic [3:0] CH_PERC = 4'd9;
    localparam logic [3:0] CH_LAST = 4'd15;

    // Widest delta carried between parser and serialiser
    localparam int DELTA_MAX_BITS = 32;
    localparam int DIGITS_MAX     = (DELTA_MAX_BITS + 6) / 7;
    localparam int DELTA_PAD_BITS = DIGITS_MAX * 7;
    localparam int EVT_BYTES      = 4;
    localparam int NUM_CTRL       = 15;

    localparam logic [7:0] CTRL_MAP [NUM_CTRL] = '{
        8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11, 8'd91, 8'd93,
        8'd64, 8'd67, 8'd120, 8'd123, 8'd126, 8'd127, 8'd121
    };

    typedef struct packed {
        logic [7:0] score_byte;
        logic       score_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       run_last;
        logic       score_done;
        logic       bad_event;
    } out_item_t;

    // One item's worth of output bytes: delta digits then event bytes
    typedef struct packed {
        logic [DELTA_MAX_BITS-1:0]  delta;
        logic [2:0]                 n_digits;
        logic [EVT_BYTES-1:0][7:0]  evt;
        logic [2:0]                 n_evt;
        logic                       done;
        logic                       bad;
    } pkt_t;

    typedef struct packed {
        logic load;
        pkt_t pkt;
    } pkt_req_t;

    function automatic logic [7:0] map_ctrl(input logic [7:0] c);
        logic [7:0] r;
        r = 8'd0;
        if (c < 8'(NUM_CTRL))
        begin
            r = CTRL_MAP[c[3:0]];
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_vol(input logic [7:0] v);
        return v[7] ? VOL_MAX : v;
    endfunction

endpackage

// ===== hw/rtl/mtm_parser.sv =====
// MUS byte parser: parse state, channel volumes, initial volume register.
// Builds one output packet per completed event or end of score. Depends on mtm_pkg.
module mtm_parser #(
    parameter int DELTA_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                accept,
    input  mtm_pkg::in_item_t   item,
    output mtm_pkg::pkt_req_t   req
);

    mtm_pkg::phase_t phase_reg, phase_next;
    logic [3:0]            chan_reg, chan_next;
    logic [2:0]            kind_reg, kind_next;
    logic                  grp_reg, grp_next;
    logic [7:0]            held_reg, held_next;
    logic [DELTA_BITS-1:0] acc_reg, acc_next;
    logic [DELTA_BITS-1:0] pend_reg, pend_next;
    logic                  fin_reg, fin_next;
    logic [7:0]            init_vol_reg;
    logic [7:0]            vol_reg [16];

    // state as seen after an optional score start
    mtm_pkg::phase_t e_phase;
    logic [3:0]            e_chan;
    logic [2:0]            e_kind;
    logic                  e_grp;
    logic [7:0]            e_held;
    logic [DELTA_BITS-1:0] e_acc;
    logic [DELTA_BITS-1:0] e_pend;
    logic                  e_fin;

    logic       start;
    logic [7:0] b;
    logic       emit, two, eot, bad, vol_we;
    logic [7:0] cmd, p0, p1;
    logic [3:0] mchan;
    logic [mtm_pkg::DELTA_MAX_BITS-1:0] delta_w;
    logic [mtm_pkg::DELTA_PAD_BITS-1:0] delta_x;

    assign start = item.score_start;
    assign b     = item.score_byte;

    always_comb
    begin
        e_phase = start ? mtm_pkg::PH_EVENT : phase_reg;
        e_chan  = start ? 4'd0 : chan_reg;
        e_kind  = start ? 3'd0 : kind_reg;
        e_grp   = start ? 1'b0 : grp_reg;
        e_held  = start ? 8'd0 : held_reg;
        e_acc   = start ? '0 : acc_reg;
        e_pend  = start ? '0 : pend_reg;
        e_fin   = start ? 1'b0 : fin_reg;
    end

    always_comb
    begin
        phase_next = e_phase;
        chan_next  = e_chan;
        kind_next  = e_kind;
        grp_next   = e_grp;
        held_next  = e_held;
        acc_next   = e_acc;
        pend_next  = e_pend;
        fin_next   = e_fin;
        emit   = 1'b0;
        two    = 1'b1;
        eot    = 1'b0;
        bad    = 1'b0;
        vol_we = 1'b0;
        cmd    = 8'd0;
        p0     = 8'd0;
        p1     = 8'd0;
        if (!e_fin)
        begin
            case (e_phase)
                mtm_pkg::PH_OP1:
                begin
                    case (e_kind)
                        mtm_pkg::KIND_PLAY:
                        begin
                            if (b[7])
                            begin
                                held_next  = b;
                                phase_next = mtm_pkg::PH_OP2;
                            end
                            else
                            begin
                                emit = 1'b1;
                                cmd  = mtm_pkg::ST_NOTE_ON;
                                p0   = {1'b0, b[6:0]};
                                p1   = mtm_pkg::clamp_vol(vol_reg[e_chan]);
                            end
                        end
                        mtm_pkg::KIND_RELEASE:
                        begin
                            emit = 1'b1;
                            cmd  = mtm_pkg::ST_NOTE_OFF;
                            p0   = b;
                        end
                        mtm_pkg::KIND_PITCH:
                        begin
                            emit = 1'b1;
                            cmd  = mtm_pkg::ST_PITCH;
                            p0   = {1'b0, b[0], 6'd0};
                            p1   = {1'b0, b[7:1]};
                        end
                        mtm_pkg::KIND_SYSTEM:
                        begin
                            emit = 1'b1;
                            cmd  = mtm_pkg::ST_CTRL;
                            p0   = mtm_pkg::map_ctrl(b);
                        end
                        mtm_pkg::KIND_CTRL:
                        begin
                            held_next  = b;
                            phase_next = mtm_pkg::PH_OP2;
                        end
                        default:
                        begin
                            phase_next = mtm_pkg::PH_EVENT;
                        end
                    endcase
                end
                mtm_pkg::PH_OP2:
                begin
                    if (e_kind == mtm_pkg::KIND_PLAY)
                    begin
                        vol_we = 1'b1;
                        emit   = 1'b1;
                        cmd    = mtm_pkg::ST_NOTE_ON;
                        p0     = {1'b0, e_held[6:0]};
                        p1     = mtm_pkg::clamp_vol(b);
                    end
                    else if (e_kind == mtm_pkg::KIND_CTRL)
                    begin
                        emit = 1'b1;
                        if (e_held == 8'd0)
                        begin
                            cmd = mtm_pkg::ST_PROGRAM;
                            p0  = b;
                            two = 1'b0;
                        end
                        else
                        begin
                            cmd = mtm_pkg::ST_CTRL;
                            p0  = mtm_pkg::map_ctrl(e_held);
                            p1  = b;
                        end
                    end
                    else
                    begin
                        phase_next = mtm_pkg::PH_EVENT;
                    end
                end
                mtm_pkg::PH_DELAY:
                begin
                    // shift in seven bits, wraps at DELTA_BITS
                    acc_next = {e_acc[DELTA_BITS-8:0], b[6:0]};
                    if (!b[7])
                    begin
                        pend_next  = acc_next;
                        phase_next = mtm_pkg::PH_EVENT;
                    end
                end
                default:
                begin
                    if (b[6:4] inside {mtm_pkg::KIND_BAD_LO, mtm_pkg::KIND_END,
                                       mtm_pkg::KIND_BAD_HI})
                    begin
                        eot        = 1'b1;
                        bad        = (b[6:4] != mtm_pkg::KIND_END);
                        fin_next   = 1'b1;
                        phase_next = mtm_pkg::PH_EVENT;
                    end
                    else
                    begin
                        chan_next  = b[3:0];
                        kind_next  = b[6:4];
                        grp_next   = b[7];
                        phase_next = mtm_pkg::PH_OP1;
                    end
                end
            endcase
            if (emit)
            begin
                pend_next = '0;
                if (e_grp)
                begin
                    acc_next   = '0;
                    phase_next = mtm_pkg::PH_DELAY;
                end
                else
                begin
                    phase_next = mtm_pkg::PH_EVENT;
                end
            end
        end
    end

    // percussion channel swap
    always_comb
    begin
        if (e_chan == mtm_pkg::CH_LAST)
        begin
            mchan = mtm_pkg::CH_PERC;
        end
        else if (e_chan == mtm_pkg::CH_PERC)
        begin
            mchan = mtm_pkg::CH_LAST;
        end
        else
        begin
            mchan = e_chan;
        end
    end

    assign delta_w = mtm_pkg::DELTA_MAX_BITS'(e_pend);
    assign delta_x = mtm_pkg::DELTA_PAD_BITS'(delta_w);

    always_comb
    begin
        req.load         = accept && (emit || eot);
        req.pkt.delta    = delta_w;
        req.pkt.done     = eot;
        req.pkt.bad      = bad;
        if (eot)
        begin
            req.pkt.n_digits = 3'd0;
            req.pkt.n_evt    = 3'd4;
            req.pkt.evt[0]   = 8'h00;
            req.pkt.evt[1]   = mtm_pkg::META_STATUS;
            req.pkt.evt[2]   = mtm_pkg::META_EOT;
            req.pkt.evt[3]   = 8'h00;
        end
        else
        begin
            if (delta_x[34:28] != 7'd0)
            begin
                req.pkt.n_digits = 3'd5;
            end
            else if (delta_x[27:21] != 7'd0)
            begin
                req.pkt.n_digits = 3'd4;
            end
            else if (delta_x[20:14] != 7'd0)
            begin
                req.pkt.n_digits = 3'd3;
            end
            else if (delta_x[13:7] != 7'd0)
            begin
                req.pkt.n_digits = 3'd2;
            end
            else
            begin
                req.pkt.n_digits = 3'd1;
            end
            req.pkt.n_evt  = two ? 3'd3 : 3'd2;
            req.pkt.evt[0] = cmd | {4'd0, mchan};
            req.pkt.evt[1] = p0;
            req.pkt.evt[2] = p1;
            req.pkt.evt[3] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mtm_pkg::PH_EVENT;
            chan_reg     <= 4'd0;
            kind_reg     <= 3'd0;
            grp_reg      <= 1'b0;
            held_reg     <= 8'd0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            fin_reg      <= 1'b0;
            init_vol_reg <= mtm_pkg::VOL_RESET;
            for (int i = 0; i < 16; i++)
            begin
                vol_reg[i] <= mtm_pkg::VOL_RESET;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                init_vol_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                chan_reg  <= chan_next;
                kind_reg  <= kind_next;
                grp_reg   <= grp_next;
                held_reg  <= held_next;
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                fin_reg   <= fin_next;
                if (start)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        vol_reg[i] <= init_vol_reg;
                    end
                end
                else if (vol_we)
                begin
                    vol_reg[e_chan] <= b;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mtm_serializer.sv =====
// Output packet register and byte serialiser for the MUS to MIDI converter.
// Depends on mtm_pkg.
module mtm_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  mtm_pkg::pkt_req_t   req,
    output logic                room,
    output logic                midi_valid,
    input  logic                midi_ready,
    output mtm_pkg::out_item_t  midi_data
);

    mtm_pkg::pkt_t pkt_reg;
    logic          valid_reg, valid_next;
    logic [2:0]    pos_reg, pos_next;

    logic [3:0] total;
    logic       last;
    logic [2:0] di;
    logic [2:0] ei;
    logic [6:0] grp;
    logic [7:0] byte_out;
    logic [mtm_pkg::DELTA_PAD_BITS-1:0] dx;

    assign total = {1'b0, pkt_reg.n_digits} + {1'b0, pkt_reg.n_evt};
    assign last  = (({1'b0, pos_reg} + 4'd1) == total);
    assign dx    = mtm_pkg::DELTA_PAD_BITS'(pkt_reg.delta);
    assign di    = pkt_reg.n_digits - 3'd1 - pos_reg;
    assign ei    = pos_reg - pkt_reg.n_digits;

    always_comb
    begin
        case (di)
            3'd0:    grp = dx[6:0];
            3'd1:    grp = dx[13:7];
            3'd2:    grp = dx[20:14];
            3'd3:    grp = dx[27:21];
            3'd4:    grp = dx[34:28];
            default: grp = 7'd0;
        endcase
        if (pos_reg < pkt_reg.n_digits)
        begin
            byte_out = {(di != 3'd0), grp};   // continuation bit on all but the last
        end
        else
        begin
            byte_out = pkt_reg.evt[ei[1:0]];
        end
    end

    assign midi_valid           = valid_reg;
    assign midi_data.midi_byte  = byte_out;
    assign midi_data.run_last   = last;
    assign midi_data.score_done = pkt_reg.done;
    assign midi_data.bad_event  = pkt_reg.bad;

    // packet slot frees as its final byte is transferred
    assign room = !valid_reg || (midi_ready && last);

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (valid_reg && midi_ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
                pos_next   = 3'd0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        if (req.load)
        begin
            valid_next = 1'b1;
            pos_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            pkt_reg <= req.pkt;
        end
    end

endmodule

// ===== hw/rtl/mus_to_midi_event_converter_core.sv =====
// Latency: the first MIDI byte of an event is offered the cycle after its last score byte.
// Throughput: one score byte per cycle while no output is pending; an event's packet holds
// the output port until its final transfer, with which the next score byte can be taken.
// Reset (rst_n, async, active low): parser idle, delays cleared, volumes and initial
// volume at 64, no output pending.
module mus_to_midi_event_converter_core #(
    parameter int DELTA_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // score byte channel
    input  logic                score_valid,
    output logic                score_ready,
    input  mtm_pkg::in_item_t   score_data,
    // MIDI byte channel
    output logic                midi_valid,
    input  logic                midi_ready,
    output mtm_pkg::out_item_t  midi_data,
    // initial volume write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    // Structure
    //   mtm_parser holds the parse state and the sixteen channel volumes. Each
    //   accepted score byte is decoded in one pass; a completed event (or the
    //   end of the score) becomes one packet: the pending delta plus up to four
    //   event bytes.
    //   mtm_serializer registers that packet and hands it out one byte per
    //   transfer: delta digits most significant first, then status and
    //   parameters, run_last on the final byte.
    //
    // A score byte is taken only while the packet slot is free or frees with
    // this cycle's final transfer, whether or not the byte finishes an event;
    // behind a packet of several bytes the input waits for all its transfers.

    logic              accept;
    logic              room;
    mtm_pkg::pkt_req_t req;

    assign cfg_ready   = 1'b1;   // register write always takes effect at once
    assign score_ready = room;
    assign accept      = score_valid && room;

    mtm_parser #(
        .DELTA_BITS (DELTA_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (score_data),
        .req       (req)
    );

    mtm_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .room       (room),
        .midi_valid (midi_valid),
        .midi_ready (midi_ready),
        .midi_data  (midi_data)
    );

endmodule

// ===== hw/rtl/mtm_checker.sv =====
// Port-level assertions for the MUS to MIDI converter, bound to the top level.
// Depends on mtm_pkg and mus_to_midi_event_converter_core_macros.svh.
`include "mus_to_midi_event_converter_core_macros.svh"

module mtm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               score_ready,
    input logic               midi_valid,
    input logic               midi_ready,
    input mtm_pkg::out_item_t midi_data
);

    // stalled output byte holds
    `MTM_ASSERT_NEXT(a_midi_hold, midi_valid && !midi_ready,
        midi_valid && $stable(midi_data), "midi byte changed while stalled")

    // input only stalls behind a pending packet
    `MTM_ASSERT_IMPL(a_stall_cause, !score_ready, midi_valid,
        "score stalled with no output pending")

    // a bad event is only ever flagged on end-of-track bytes
    `MTM_ASSERT_IMPL(a_bad_done, midi_valid && midi_data.bad_event, midi_data.score_done,
        "bad_event without score_done")

    // a packet never stops short of its last byte
    `MTM_ASSERT_NEXT(a_run_cont, midi_valid && midi_ready && !midi_data.run_last,
        midi_valid, "packet ended without run_last")

endmodule

bind mus_to_midi_event_converter_core mtm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .score_ready (score_ready),
    .midi_valid  (midi_valid),
    .midi_ready  (midi_ready),
    .midi_data   (midi_data)
);
